### sv/lobcd_pkg.sv
// Shared types and codes for the limit order book cross detector.
// No dependencies; imported by every module of the block.
`default_nettype none
package lobcd_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam int COUNT_OUT_W = 9;

    typedef struct packed {
        logic [63:0] id;
        logic [31:0] price;
        logic [31:0] size;
        logic [47:0] created;
    } order_t;

    typedef struct packed {
        logic match_en;
        logic insert_en;
        logic remove_en;
    } chain_ctrl_t;

endpackage
`default_nettype wire

### sv/limit_order_book_cross_detect.sv
// Top level of the limit order book cross detector: control sequencer, side
// counts and result register. Depends on lobcd_pkg and lobcd_chain.
//
// Usage:
//   Slave channel s_*: one transaction per order event (add, remove, query).
//   Master channel m_*: one transaction per accepted event, carrying ok, the
//   cross check, the best long and short orders and both side counts.
//   Each side of the book is a chain of MAX_ORDERS cells kept in price then
//   arrival order, so the best order always sits in the head cell.
//   An event passes through capture, id compare in every cell, chain update
//   (insert shift or remove compaction, one neighbor step) and report. The
//   next event is taken in the cycle after the report, so the block takes no
//   new event before the last is reported; book depth does not change this.
//   Results land in an output register; while the receiver stalls the block
//   still takes and processes one more event, then holds in the report step
//   until the register frees.
//   Reset (aresetn low, synchronous) empties both chains and clears the
//   counts and the output valid flag; no clearing pass is needed.
`default_nettype none
module limit_order_book_cross_detect import lobcd_pkg::*; #(
    parameter int MAX_ORDERS = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // op[1:0], order_id[65:2], is_short[66], price[98:67], quantity[130:99],
    // created_ms[178:131], zero fill up to 183
    input  wire logic [183:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // ok[0], crossed[1], maker_is_short[2], fill_size[34:3], exec_price[66:35],
    // best_long_id[130:67], best_long_price[162:131], best_short_id[226:163],
    // best_short_price[258:227], long_count[267:259], short_count[276:268],
    // zero fill up to 279
    output logic [279:0]      m_tdata
);

    localparam int CW = $clog2(MAX_ORDERS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MATCH  = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    logic [1:0]     op_reg;
    logic           side_reg;
    order_t         ord_reg;
    logic           ok_reg, ok_next;
    logic [CW-1:0]  long_cnt_reg, long_cnt_next;
    logic [CW-1:0]  short_cnt_reg, short_cnt_next;
    logic           m_valid_reg;
    logic [279:0]   m_data_reg;

    chain_ctrl_t    long_ctrl, short_ctrl;
    logic           long_head_v, short_head_v;
    order_t         long_head, short_head;
    logic           long_hit, short_hit;
    logic           found;
    logic           book_full;
    logic           in_fire, load_out;

    // result fields
    logic           crossed, maker_short;
    logic [31:0]    fill_size, exec_price;
    logic [63:0]    bl_id, bs_id;
    logic [31:0]    bl_price, bs_price;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_REPORT) && (!m_valid_reg || m_tready);
    assign found    = long_hit || short_hit;
    assign book_full = ({1'b0, long_cnt_reg} + {1'b0, short_cnt_reg})
                       >= (CW+1)'(MAX_ORDERS);

    lobcd_chain #(.DEPTH(MAX_ORDERS)) u_long (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (long_ctrl),
        .side_short (1'b0),
        .new_ord    (ord_reg),
        .head_valid (long_head_v),
        .head_ord   (long_head),
        .any_hit    (long_hit)
    );

    lobcd_chain #(.DEPTH(MAX_ORDERS)) u_short (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (short_ctrl),
        .side_short (1'b1),
        .new_ord    (ord_reg),
        .head_valid (short_head_v),
        .head_ord   (short_head),
        .any_hit    (short_hit)
    );

    // Sequence one event through compare, update and report.
    always_comb begin
        state_next     = state_reg;
        ok_next        = ok_reg;
        long_cnt_next  = long_cnt_reg;
        short_cnt_next = short_cnt_reg;
        long_ctrl      = '0;
        short_ctrl     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                long_ctrl.match_en  = 1'b1;
                short_ctrl.match_en = 1'b1;
                state_next          = ST_UPDATE;
            end
            ST_UPDATE: begin
                ok_next = 1'b0;
                case (op_reg)
                    OP_ADD: begin
                        if (!found && !book_full) begin
                            ok_next = 1'b1;
                            if (side_reg) begin
                                short_ctrl.insert_en = 1'b1;
                                short_cnt_next       = short_cnt_reg + 1'b1;
                            end else begin
                                long_ctrl.insert_en = 1'b1;
                                long_cnt_next       = long_cnt_reg + 1'b1;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        ok_next              = found;
                        long_ctrl.remove_en  = 1'b1;
                        short_ctrl.remove_en = 1'b1;
                        if (long_hit) begin
                            long_cnt_next = long_cnt_reg - 1'b1;
                        end
                        if (short_hit) begin
                            short_cnt_next = short_cnt_reg - 1'b1;
                        end
                    end
                    OP_QUERY: begin
                        ok_next = found;
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Cross check on the two head cells.
    always_comb begin
        bl_id       = long_head_v  ? long_head.id     : 64'd0;
        bl_price    = long_head_v  ? long_head.price  : 32'd0;
        bs_id       = short_head_v ? short_head.id    : 64'd0;
        bs_price    = short_head_v ? short_head.price : 32'd0;
        crossed     = long_head_v && short_head_v && (long_head.price >= short_head.price);
        maker_short = crossed && (long_head.created > short_head.created);
        fill_size   = 32'd0;
        exec_price  = 32'd0;
        if (crossed) begin
            fill_size  = (long_head.size < short_head.size) ? long_head.size
                                                            : short_head.size;
            exec_price = maker_short ? short_head.price : long_head.price;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ok_reg        <= 1'b0;
            long_cnt_reg  <= '0;
            short_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ok_reg        <= ok_next;
            long_cnt_reg  <= long_cnt_next;
            short_cnt_reg <= short_cnt_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the event and hold the result payload.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg        <= s_tdata[1:0];
            ord_reg.id    <= s_tdata[65:2];
            side_reg      <= s_tdata[66];
            ord_reg.price <= s_tdata[98:67];
            ord_reg.size  <= s_tdata[130:99];
            ord_reg.created <= s_tdata[178:131];
        end
        if (load_out) begin
            m_data_reg <= {3'd0,
                           COUNT_OUT_W'(short_cnt_reg),
                           COUNT_OUT_W'(long_cnt_reg),
                           bs_price, bs_id, bl_price, bl_id,
                           exec_price, fill_size, maker_short, crossed, ok_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Book never holds more orders than it has slots.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, long_cnt_reg} + {1'b0, short_cnt_reg}) <= (CW+1)'(MAX_ORDERS))
        else $error("order count exceeds capacity");

    // An accepted event reaches the report step through the match and update steps.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> ##3 (state_reg == ST_REPORT))
        else $error("event did not reach report step");

    // A report without a cross carries no fill.
    a_no_cross_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[66:3] == 64'd0 && !m_tdata[2]))
        else $error("fill reported without cross");

endmodule
`default_nettype wire

### sv/lobcd_cell.sv
// One slot of a sorted order chain: holds one order, compares it with the
// broadcast order and takes a neighbor's order on insert or remove. Uses lobcd_pkg.
`default_nettype none
module lobcd_cell import lobcd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire chain_ctrl_t ctrl,
    input  wire logic        remove_shift,
    input  wire logic        side_short,
    input  wire order_t      new_ord,
    input  wire logic        prev_beats,
    input  wire logic        prev_valid,
    input  wire order_t      prev_ord,
    input  wire logic        next_valid,
    input  wire order_t      next_ord,
    output logic             valid,
    output order_t           ord,
    output logic             beats,
    output logic             hit
);

    logic   valid_reg;
    logic   hit_reg;
    order_t ord_reg;

    // new order ranks ahead of this slot (an empty slot ranks last)
    assign beats = !valid_reg ||
                   (side_short ? (new_ord.price < ord_reg.price)
                               : (new_ord.price > ord_reg.price));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            if (ctrl.match_en) begin
                hit_reg <= valid_reg && (ord_reg.id == new_ord.id);
            end
            if (ctrl.insert_en && beats) begin
                valid_reg <= prev_beats ? prev_valid : 1'b1;
            end else if (remove_shift) begin
                valid_reg <= next_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.insert_en && beats) begin
            ord_reg <= prev_beats ? prev_ord : new_ord;
        end else if (remove_shift) begin
            ord_reg <= next_ord;
        end
    end

    assign valid = valid_reg;
    assign ord   = ord_reg;
    assign hit   = hit_reg;

endmodule
`default_nettype wire

### sv/lobcd_chain.sv
// Sorted chain of order cells for one side of the book, best order at the head.
// Depends on lobcd_pkg and lobcd_cell.
`default_nettype none
module lobcd_chain import lobcd_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire chain_ctrl_t ctrl,
    input  wire logic        side_short,
    input  wire order_t      new_ord,
    output logic             head_valid,
    output order_t           head_ord,
    output logic             any_hit
);

    logic   [DEPTH-1:0] valid_w;
    logic   [DEPTH-1:0] beats_w;
    logic   [DEPTH-1:0] hit_w;
    logic   [DEPTH-1:0] hit_prefix;
    order_t             ord_w [DEPTH];

    // slots at or behind the removed order pull from their successor
    always_comb begin
        hit_prefix = hit_w;
        for (int s = 1; s < DEPTH; s = s * 2) begin
            hit_prefix = hit_prefix | (hit_prefix << s);
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic   pv, pb, nv;
        order_t po, no;
        if (i == 0) begin : g_head
            assign pb = 1'b0;
            assign pv = 1'b0;
            assign po = '0;
        end else begin : g_body
            assign pb = beats_w[i-1];
            assign pv = valid_w[i-1];
            assign po = ord_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign nv = 1'b0;
            assign no = '0;
        end else begin : g_inner
            assign nv = valid_w[i+1];
            assign no = ord_w[i+1];
        end
        lobcd_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .remove_shift (ctrl.remove_en && hit_prefix[i]),
            .side_short   (side_short),
            .new_ord      (new_ord),
            .prev_beats   (pb),
            .prev_valid   (pv),
            .prev_ord     (po),
            .next_valid   (nv),
            .next_ord     (no),
            .valid        (valid_w[i]),
            .ord          (ord_w[i]),
            .beats        (beats_w[i]),
            .hit          (hit_w[i])
        );
    end

    assign head_valid = valid_w[0];
    assign head_ord   = ord_w[0];
    assign any_hit    = hit_prefix[DEPTH-1];

endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for limit_order_book_cross_detect: drives order events over the s_ stream,
// predicts the book report for each event, and checks every m_ transaction field by field.
// Depends on lobcd_pkg and the RTL of the block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import lobcd_pkg::*;

    localparam int BOOK_DEPTH = 256;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] order_id;
        logic        is_short;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [47:0] created_ms;
    } event_t;

    typedef struct packed {
        logic        ok;
        logic        crossed;
        logic        maker_is_short;
        logic [31:0] fill_size;
        logic [31:0] exec_price;
        logic [63:0] best_long_id;
        logic [31:0] best_long_price;
        logic [63:0] best_short_id;
        logic [31:0] best_short_price;
        logic [8:0]  long_count;
        logic [8:0]  short_count;
    } report_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // op[1:0], order_id[65:2], is_short[66], price[98:67], quantity[130:99],
    // created_ms[178:131], zero fill up to 183
    logic [183:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // ok[0], crossed[1], maker_is_short[2], fill_size[34:3], exec_price[66:35],
    // best_long_id[130:67], best_long_price[162:131], best_short_id[226:163],
    // best_short_price[258:227], long_count[267:259], short_count[276:268]
    logic [279:0] m_tdata;

    limit_order_book_cross_detect #(.MAX_ORDERS(BOOK_DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // Mirror of the book.
    logic        book_valid   [BOOK_DEPTH];
    logic [63:0] book_id      [BOOK_DEPTH];
    logic        book_side    [BOOK_DEPTH];
    logic [31:0] book_price   [BOOK_DEPTH];
    logic [31:0] book_size    [BOOK_DEPTH];
    logic [47:0] book_created [BOOK_DEPTH];
    logic [31:0] book_arrival [BOOK_DEPTH];
    logic [31:0] arrival_seq;
    int          longs_resting, shorts_resting;

    report_t     pending_reports[$];
    logic [63:0] live_ids[$];
    int          error_count = 0;
    int          sent_count = 0, checked_count = 0, cross_count = 0;
    int          send_idle_pct = 0, recv_idle_pct = 0;
    bit          hold_receiver = 1'b0;
    bit          all_sent = 1'b0;

    function automatic int find_order(logic [63:0] id);
        for (int i = 0; i < BOOK_DEPTH; i++)
            if (book_valid[i] && book_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int front_order(logic side);
        int          best;
        logic [31:0] age_i, age_b;
        best = -1;
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            if (!book_valid[i] || book_side[i] != side) continue;
            if (best < 0) begin
                best = i;
            end else if (side ? book_price[i] < book_price[best]
                              : book_price[i] > book_price[best]) begin
                best = i;
            end else if (book_price[i] == book_price[best]) begin
                age_i = arrival_seq - book_arrival[i];
                age_b = arrival_seq - book_arrival[best];
                if (age_i > age_b) best = i;
            end
        end
        return best;
    endfunction

    // Apply one event to the mirror and return the report the block must give.
    function automatic report_t apply_order_event(event_t ev);
        report_t r;
        int      k, bl, bs;
        r = '0;
        k = find_order(ev.order_id);
        case (ev.op)
            OP_ADD: begin
                if (k < 0) begin
                    for (int i = 0; i < BOOK_DEPTH; i++) begin
                        if (!book_valid[i]) begin
                            book_valid[i]   = 1'b1;
                            book_id[i]      = ev.order_id;
                            book_side[i]    = ev.is_short;
                            book_price[i]   = ev.price;
                            book_size[i]    = ev.quantity;
                            book_created[i] = ev.created_ms;
                            book_arrival[i] = arrival_seq;
                            arrival_seq++;
                            if (ev.is_short) shorts_resting++;
                            else longs_resting++;
                            r.ok = 1'b1;
                            break;
                        end
                    end
                end
            end
            OP_REMOVE: begin
                if (k >= 0) begin
                    book_valid[k] = 1'b0;
                    if (book_side[k]) shorts_resting--;
                    else longs_resting--;
                    r.ok = 1'b1;
                end
            end
            OP_QUERY: r.ok = (k >= 0);
            default: r.ok = 1'b0;
        endcase
        bl = front_order(1'b0);
        bs = front_order(1'b1);
        if (bl >= 0) begin
            r.best_long_id    = book_id[bl];
            r.best_long_price = book_price[bl];
        end
        if (bs >= 0) begin
            r.best_short_id    = book_id[bs];
            r.best_short_price = book_price[bs];
        end
        if (bl >= 0 && bs >= 0 && book_price[bl] >= book_price[bs]) begin
            r.crossed        = 1'b1;
            r.maker_is_short = !(book_created[bl] <= book_created[bs]);
            r.fill_size      = book_size[bl] < book_size[bs] ? book_size[bl] : book_size[bs];
            r.exec_price     = r.maker_is_short ? book_price[bs] : book_price[bl];
        end
        r.long_count  = longs_resting[8:0];
        r.short_count = shorts_resting[8:0];
        return r;
    endfunction

    function automatic logic [183:0] pack_event(event_t ev);
        return {5'd0, ev.created_ms, ev.quantity, ev.price, ev.is_short, ev.order_id, ev.op};
    endfunction

    function automatic report_t unpack_report(logic [279:0] d);
        report_t r;
        r.ok               = d[0];
        r.crossed          = d[1];
        r.maker_is_short   = d[2];
        r.fill_size        = d[34:3];
        r.exec_price       = d[66:35];
        r.best_long_id     = d[130:67];
        r.best_long_price  = d[162:131];
        r.best_short_id    = d[226:163];
        r.best_short_price = d[258:227];
        r.long_count       = d[267:259];
        r.short_count      = d[276:268];
        return r;
    endfunction

    // Drive one transaction; the mirror is updated when the handshake completes.
    task automatic send_event(event_t ev, bit has_known, report_t known);
        report_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_event(ev);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = apply_order_event(ev);
        if (has_known && r != known) begin
            $error("directed row %0d: predictor disagrees with table", sent_count);
            error_count++;
        end
        pending_reports.insert(pending_reports.size(), has_known ? known : r);
        if (ev.op == OP_ADD && r.ok) live_ids.insert(live_ids.size(), ev.order_id);
        sent_count++;
        // Hold valid high into the next call; lower it only if idling follows.
    endtask

    // Receiver: stall at random, or hold off entirely while hold_receiver is set.
    always @(posedge aclk) begin
        if (!aresetn || hold_receiver) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result transaction against the oldest expected report.
    always @(posedge aclk) begin
        report_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_report(m_tdata);
            if (pending_reports.size() == 0) begin
                $error("result with no expected report");
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                checked_count++;
                if (want.crossed) cross_count++;
                if (got.ok != want.ok) begin
                    $error("ok: expected %0d actual %0d", want.ok, got.ok); error_count++;
                end
                if (got.crossed != want.crossed) begin
                    $error("crossed: expected %0d actual %0d", want.crossed, got.crossed);
                    error_count++;
                end
                if (got.maker_is_short != want.maker_is_short) begin
                    $error("maker_is_short: expected %0d actual %0d",
                           want.maker_is_short, got.maker_is_short);
                    error_count++;
                end
                if (got.fill_size != want.fill_size) begin
                    $error("fill_size: expected %0h actual %0h", want.fill_size, got.fill_size);
                    error_count++;
                end
                if (got.exec_price != want.exec_price) begin
                    $error("exec_price: expected %0h actual %0h", want.exec_price,
                           got.exec_price);
                    error_count++;
                end
                if (got.best_long_id != want.best_long_id) begin
                    $error("best_long_id: expected %0h actual %0h", want.best_long_id,
                           got.best_long_id);
                    error_count++;
                end
                if (got.best_long_price != want.best_long_price) begin
                    $error("best_long_price: expected %0h actual %0h", want.best_long_price,
                           got.best_long_price);
                    error_count++;
                end
                if (got.best_short_id != want.best_short_id) begin
                    $error("best_short_id: expected %0h actual %0h", want.best_short_id,
                           got.best_short_id);
                    error_count++;
                end
                if (got.best_short_price != want.best_short_price) begin
                    $error("best_short_price: expected %0h actual %0h", want.best_short_price,
                           got.best_short_price);
                    error_count++;
                end
                if (got.long_count != want.long_count) begin
                    $error("long_count: expected %0d actual %0d", want.long_count,
                           got.long_count);
                    error_count++;
                end
                if (got.short_count != want.short_count) begin
                    $error("short_count: expected %0d actual %0d", want.short_count,
                           got.short_count);
                    error_count++;
                end
            end
        end
    end

    function automatic event_t mk(logic [1:0] op, logic [63:0] id, logic sd,
                                  logic [31:0] p, logic [31:0] q, logic [47:0] c);
        event_t ev;
        ev.op = op; ev.order_id = id; ev.is_short = sd;
        ev.price = p; ev.quantity = q; ev.created_ms = c;
        return ev;
    endfunction

    function automatic report_t rep(logic ok, logic cr, logic mk_s, logic [31:0] fs,
                                    logic [31:0] ep, logic [63:0] lid, logic [31:0] lp,
                                    logic [63:0] sid, logic [31:0] sp,
                                    logic [8:0] lc, logic [8:0] sc);
        return {ok, cr, mk_s, fs, ep, lid, lp, sid, sp, lc, sc};
    endfunction

    // Random content over the full field ranges, or clustered so prices and ids collide.
    function automatic event_t random_event();
        event_t ev;
        int     pick;
        logic [63:0] id;
        pick = $urandom_range(99);
        id = {$urandom, $urandom};
        if (live_ids.size() > 0 && $urandom_range(2) == 0)
            id = live_ids[$urandom_range(live_ids.size() - 1)];
        else if ($urandom_range(1) == 0)
            id = 64'($urandom_range(300));
        ev.order_id = id;
        ev.is_short = 1'($urandom_range(1));
        ev.price    = ($urandom_range(3) == 0) ? $urandom : 32'd1000 + $urandom_range(20);
        ev.quantity = ($urandom_range(3) == 0) ? $urandom : $urandom_range(500);
        ev.created_ms = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) :
                        48'($urandom_range(8));
        if (pick < 50)      ev.op = OP_ADD;
        else if (pick < 80) ev.op = OP_REMOVE;
        else if (pick < 95) ev.op = OP_QUERY;
        else                ev.op = OP_UNUSED;
        return ev;
    endfunction

    initial begin
        event_t      ev_table  [$];
        report_t     want_table[$];
        bit          known_table[$];
        report_t     none;
        logic [63:0] drain_id;
        int          wait_cycles;

        none = '0;
        for (int i = 0; i < BOOK_DEPTH; i++) book_valid[i] = 1'b0;
        arrival_seq = '0;
        longs_resting = 0;
        shorts_resting = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: expected reports typed in where they are obvious.
        ev_table.insert(ev_table.size(), mk(OP_QUERY, 64'd0, 0, 0, 0, 0));
        want_table.insert(want_table.size(), none);
        known_table.insert(known_table.size(), 1);
        ev_table.insert(ev_table.size(), mk(OP_REMOVE, '1, 0, 0, 0, 0));
        want_table.insert(want_table.size(), none);
        known_table.insert(known_table.size(), 1);
        ev_table.insert(ev_table.size(), mk(OP_UNUSED, '1, 1, '1, '1, '1));
        want_table.insert(want_table.size(), none);
        known_table.insert(known_table.size(), 1);
        ev_table.insert(ev_table.size(), mk(OP_ADD, '1, 0, '1, '1, '1));
        want_table.insert(want_table.size(), rep(1, 0, 0, 0, 0, '1, '1, 0, 0, 1, 0));
        known_table.insert(known_table.size(), 1);
        ev_table.insert(ev_table.size(), mk(OP_ADD, 64'd0, 1, 32'd0, 32'd0, 48'd0));
        want_table.insert(want_table.size(), rep(1, 1, 1, 0, 0, '1, '1, 0, 0, 1, 1));
        known_table.insert(known_table.size(), 1);
        // duplicate add on the other side
        ev_table.insert(ev_table.size(), mk(OP_ADD, '1, 1, 32'd5, 32'd5, 48'd5));
        want_table.insert(want_table.size(), rep(0, 1, 1, 0, 0, '1, '1, 0, 0, 1, 1));
        known_table.insert(known_table.size(), 1);
        ev_table.insert(ev_table.size(), mk(OP_QUERY, '1, 0, 0, 0, 0));
        want_table.insert(want_table.size(), rep(1, 1, 1, 0, 0, '1, '1, 0, 0, 1, 1));
        known_table.insert(known_table.size(), 1);
        ev_table.insert(ev_table.size(), mk(OP_REMOVE, '1, 0, 0, 0, 0));
        want_table.insert(want_table.size(), rep(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        known_table.insert(known_table.size(), 1);
        ev_table.insert(ev_table.size(), mk(OP_REMOVE, 64'd0, 0, 0, 0, 0));
        want_table.insert(want_table.size(), rep(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        known_table.insert(known_table.size(), 1);
        // equal prices, time priority within a price, created-time tie goes to long
        ev_table.insert(ev_table.size(), mk(OP_ADD, 64'h10, 0, 32'd100, 32'd7, 48'd50));
        ev_table.insert(ev_table.size(), mk(OP_ADD, 64'h11, 0, 32'd100, 32'd3, 48'd10));
        ev_table.insert(ev_table.size(), mk(OP_ADD, 64'h20, 1, 32'd100, 32'd9, 48'd50));
        ev_table.insert(ev_table.size(), mk(OP_ADD, 64'h21, 1, 32'd90, 32'd2, 48'd40));
        ev_table.insert(ev_table.size(), mk(OP_REMOVE, 64'h10, 0, 0, 0, 0));
        ev_table.insert(ev_table.size(), mk(OP_ADD, 64'h12, 0, 32'd120, '1, 48'd40));
        ev_table.insert(ev_table.size(), mk(OP_REMOVE, 64'h21, 0, 0, 0, 0));
        ev_table.insert(ev_table.size(), mk(OP_QUERY, 64'h21, 0, 0, 0, 0));
        ev_table.insert(ev_table.size(), mk(OP_REMOVE, 64'h11, 0, 0, 0, 0));
        ev_table.insert(ev_table.size(), mk(OP_REMOVE, 64'h12, 0, 0, 0, 0));
        ev_table.insert(ev_table.size(), mk(OP_REMOVE, 64'h20, 0, 0, 0, 0));
        while (want_table.size() < ev_table.size()) begin
            want_table.insert(want_table.size(), none);
            known_table.insert(known_table.size(), 0);
        end
        for (int i = 0; i < ev_table.size(); i++)
            send_event(ev_table[i], known_table[i], want_table[i]);

        // Fill the table to the full-book case, try one more add, then drain.
        for (int i = 0; i <= BOOK_DEPTH; i++)
            send_event(mk(OP_ADD, 64'h1000 + i, i[0], 32'd500 + i[3:0], $urandom,
                          48'($urandom_range(4))), 0, none);
        while (live_ids.size() > 0) begin
            drain_id = live_ids.pop_front();
            send_event(mk(OP_REMOVE, drain_id, 0, 0, 0, 0), 0, none);
        end

        // Random part in three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 8 : 0;
            for (int n = 0; n < 500; n++) begin
                if (phase == 2 && n == 100) hold_receiver = 1'b1;
                send_event(random_event(), 0, none);
                // keep the id pool close to the book contents
                if (live_ids.size() > 400) void'(live_ids.pop_front());
            end
        end
        s_tvalid <= 1'b0;
        all_sent = 1'b1;
    end

    // Long receiver hold-off, counted here so the sender keeps pushing into a full block.
    initial begin
        wait (hold_receiver);
        repeat (200) @(posedge aclk);
        hold_receiver = 1'b0;
    end

    initial begin
        wait (all_sent);
        while (pending_reports.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Covered %0d order events, %0d reports checked, %0d with a cross.",
                 sent_count, checked_count, cross_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
sv/lobcd_pkg.sv
sv/lobcd_cell.sv
sv/lobcd_chain.sv
sv/limit_order_book_cross_detect.sv
tb/testbench.sv
